FILE: rtl/word_ngram_signature_gen_macros.svh
// Assertion macros used by the signature generator checker.
`ifndef WORD_NGRAM_SIGNATURE_GEN_MACROS_SVH
`define WORD_NGRAM_SIGNATURE_GEN_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define WNGS_ASSERT_IMPLY(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("check failed in %m");

// Next-cycle implication, sampled on clk, quiet during reset
`define WNGS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("check failed in %m");

`endif

FILE: rtl/wngs_pkg.sv
// Shared constants, types and character classes of the signature generator.
package wngs_pkg;

    localparam int MAX_WINDOW_WORDS = 8;
    localparam int COUNT_BITS       = 32;
    localparam int HASH_W           = 64;
    localparam int PTR_W = (MAX_WINDOW_WORDS > 1) ? $clog2(MAX_WINDOW_WORDS) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW_WORDS + 1);

    localparam logic [HASH_W-1:0] HASH_BASE = 64'd31;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WORDS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PUNCT_ENABLE = 2'd2;

    localparam logic [4:0] ZERO_BITS_RST    = 5'd4;
    localparam logic [3:0] WINDOW_WORDS_RST = 4'd3;
    localparam logic       PUNCT_ENABLE_RST = 1'b0;

    // result kinds
    localparam logic KIND_SIG   = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NEXT,
        S_PUSH,
        S_FRD,
        S_FUSE,
        S_FMUL,
        S_CHECK,
        S_COUNT,
        S_END
    } state_t;

    // one window entry: word hash and 31^length
    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [HASH_W-1:0] power;
    } win_entry_t;

    // multiply-add request: a * b + c, low 64 bits
    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
        logic [HASH_W-1:0] c;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] value;
    } mul_rsp_t;

    function automatic logic is_space(input logic [7:0] c);
        // space, tab, newline
        return c inside {8'h20, 8'h09, 8'h0A};
    endfunction

    function automatic logic is_symbol_char(input logic [7:0] c);
        // ! through /, : through @, [ through `, { through ~
        return c inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]};
    endfunction

endpackage

FILE: rtl/wngs_mul.sv
// Iterative 64-bit multiply-add (low half) on one shared 32x32 multiplier.
module wngs_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  wngs_pkg::mul_req_t req,
    output wngs_pkg::mul_rsp_t rsp
);
    import wngs_pkg::*;

    logic [HASH_W-1:0] a_reg;
    logic [HASH_W-1:0] b_reg;
    logic [HASH_W-1:0] acc_reg;
    logic [HASH_W-1:0] acc_next;
    logic [HASH_W-1:0] prod_reg;
    logic [HASH_W-1:0] prod_next;
    logic [1:0]        phase_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [31:0]       mul_x;
    logic [31:0]       mul_y;

    // operand halves per pass: lo*lo, lo*hi, hi*lo
    always_comb
    begin
        case (phase_reg)
            2'd0:    begin mul_x = a_reg[31:0];  mul_y = b_reg[31:0];  end
            2'd1:    begin mul_x = a_reg[31:0];  mul_y = b_reg[63:32]; end
            2'd2:    begin mul_x = a_reg[63:32]; mul_y = b_reg[31:0];  end
            default: begin mul_x = a_reg[31:0];  mul_y = b_reg[31:0];  end
        endcase
        prod_next = {32'b0, mul_x} * {32'b0, mul_y};
    end

    // accumulate the product of the previous pass
    always_comb
    begin
        case (phase_reg)
            2'd1:    acc_next = acc_reg + prod_reg;
            2'd2:    acc_next = acc_reg + {prod_reg[31:0], 32'b0};
            2'd3:    acc_next = acc_reg + {prod_reg[31:0], 32'b0};
            default: acc_next = acc_reg;
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (phase_reg == 2'd3);
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                    busy_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= req.c;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            prod_reg <= prod_next;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = acc_reg;

endmodule

FILE: rtl/word_ngram_signature_gen.sv
// Word n-gram hash signature generator, top level; takes one request at a time.
// Per request: a byte that ends no word is only taken; a finished word is pushed into the window
// memory and, once the effective window is full, folded (per step: one memory read, one set-up and,
// after the first step, the shared 32x32 multiply-add); punctuation is pushed as a word of its own.
// End of file adds a count. A stalled output holds the FSM and the input.
// Reset (async, active low): registers to defaults, file state cleared, window memory left as is.
module word_ngram_signature_gen (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [wngs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wngs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      text_byte,
    input  logic                            byte_present,
    input  logic                            end_mark,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            item_kind,
    output logic [wngs_pkg::HASH_W-1:0]     payload,
    output logic                            run_last
);
    import wngs_pkg::*;

    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(MAX_WINDOW_WORDS - 1);
    localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(MAX_WINDOW_WORDS);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_WINDOW_WORDS);

    // configuration
    logic [4:0] zero_bits_reg;
    logic [3:0] window_words_reg;
    logic       punct_enable_reg;

    // control state
    state_t            state_reg;
    state_t            state_next;
    logic              in_word_reg;
    logic              pend_a_reg;
    logic              pend_p_reg;
    logic              pend_eof_reg;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_idx_reg;
    logic [CNT_W-1:0]  words_seen_reg;
    logic [CNT_W-1:0]  fold_left_reg;
    logic              fold_first_reg;
    logic [COUNT_BITS-1:0] sig_count_reg;
    logic              held_valid_reg;
    logic              out_valid_reg;

    // payload state
    logic [HASH_W-1:0] cur_hash_reg;
    logic [HASH_W-1:0] cur_power_reg;
    logic [7:0]        byte_reg;
    logic [HASH_W-1:0] acc_h_reg;
    logic              held_kind_reg;
    logic [HASH_W-1:0] held_payload_reg;
    logic              item_kind_reg;
    logic [HASH_W-1:0] payload_reg;
    logic              run_last_reg;

    // window memory
    win_entry_t win_mem [MAX_WINDOW_WORDS];
    win_entry_t rd_q;
    win_entry_t mem_wdata;
    logic       mem_we;
    logic       mem_re;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    // combinational helpers
    logic              in_acc;
    logic              c_space;
    logic              c_punct;
    logic              ev_a;
    logic              ev_p;
    logic [CNT_W-1:0]  nw_eff;
    logic [CNT_W-1:0]  words_seen_inc;
    logic              fold_go;
    logic [PTR_W:0]    old_sum;
    logic [PTR_W-1:0]  oldest_idx;
    logic [HASH_W-1:0] zmask;
    logic              sig_pass;
    logic              out_free;
    logic              commit;
    logic              out_load;

    wngs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // input decode
    always_comb
    begin
        in_acc  = in_valid && !in_stall;
        c_space = is_space(text_byte);
        c_punct = punct_enable_reg && is_symbol_char(text_byte);
        if (byte_present)
            ev_a = (c_space || c_punct) ? in_word_reg : end_mark;
        else
            ev_a = end_mark && in_word_reg;
        ev_p = byte_present && c_punct && !c_space;
    end

    // window bookkeeping
    always_comb
    begin
        if (window_words_reg == 4'd0)
            nw_eff = CNT_W'(1);
        else if (32'(window_words_reg) > MAX_WINDOW_WORDS)
            nw_eff = CNT_MAX;
        else
            nw_eff = CNT_W'(window_words_reg);
        words_seen_inc = (words_seen_reg == CNT_MAX) ? words_seen_reg
                                                     : words_seen_reg + 1'b1;
        fold_go = words_seen_inc >= nw_eff;
        // oldest = newest - (nw - 1), newest sits at wr_ptr
        old_sum = {1'b0, wr_ptr_reg} + DEPTH_X + 1'b1 - (PTR_W + 1)'(nw_eff);
        if (old_sum >= DEPTH_X)
            oldest_idx = PTR_W'(old_sum - DEPTH_X);
        else
            oldest_idx = PTR_W'(old_sum);
    end

    // signature test and result hand-off
    always_comb
    begin
        zmask    = (64'd1 << zero_bits_reg) - 64'd1;
        sig_pass = (acc_h_reg & zmask) == '0;
        out_free = !out_valid_reg || !out_stall;
        commit   = ((state_reg == S_CHECK && sig_pass) || state_reg == S_COUNT)
                   && !(held_valid_reg && !out_free);
        out_load = (commit && held_valid_reg)
                   || (state_reg == S_END && held_valid_reg && out_free);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_acc && (ev_a || ev_p || end_mark))
                    state_next = S_NEXT;
            S_NEXT:
                if (pend_a_reg || pend_p_reg)
                    state_next = S_PUSH;
                else if (pend_eof_reg)
                    state_next = S_COUNT;
                else
                    state_next = S_END;
            S_PUSH:
                state_next = fold_go ? S_FRD : S_NEXT;
            S_FRD:
                state_next = S_FUSE;
            S_FUSE:
                if (!fold_first_reg)
                    state_next = S_FMUL;
                else if (fold_left_reg == '0)
                    state_next = S_CHECK;
                else
                    state_next = S_FRD;
            S_FMUL:
                if (mul_rsp.done)
                    state_next = (fold_left_reg == '0) ? S_CHECK : S_FRD;
            S_CHECK:
                if (!sig_pass || commit)
                    state_next = S_NEXT;
            S_COUNT:
                if (commit)
                    state_next = S_NEXT;
            S_END:
                if (!held_valid_reg || out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // per-state outputs
    always_comb
    begin
        in_stall = (state_reg != S_IDLE);
        mem_we   = (state_reg == S_PUSH);
        mem_re   = (state_reg == S_FRD);
        if (pend_a_reg)
            mem_wdata = '{hash: cur_hash_reg, power: cur_power_reg};
        else
            mem_wdata = '{hash: {56'b0, byte_reg}, power: HASH_BASE};
        mul_req.start = (state_reg == S_FUSE) && !fold_first_reg;
        mul_req.a     = acc_h_reg;
        mul_req.b     = rd_q.power;
        mul_req.c     = rd_q.hash;
    end

    // window memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            win_mem[wr_ptr_reg] <= mem_wdata;
        if (mem_re)
            rd_q <= win_mem[rd_idx_reg];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_bits_reg    <= ZERO_BITS_RST;
            window_words_reg <= WINDOW_WORDS_RST;
            punct_enable_reg <= PUNCT_ENABLE_RST;
            state_reg        <= S_IDLE;
            in_word_reg      <= 1'b0;
            pend_a_reg       <= 1'b0;
            pend_p_reg       <= 1'b0;
            pend_eof_reg     <= 1'b0;
            wr_ptr_reg       <= '0;
            rd_idx_reg       <= '0;
            words_seen_reg   <= '0;
            fold_left_reg    <= '0;
            fold_first_reg   <= 1'b0;
            sig_count_reg    <= '0;
            held_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            cur_hash_reg     <= '0;
            cur_power_reg    <= 64'd1;
        end
        else
        begin
            state_reg <= state_next;

            // register writes
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ZERO_BITS:    zero_bits_reg    <= cfg_data[4:0];
                    CFG_WINDOW_WORDS: window_words_reg <= cfg_data[3:0];
                    CFG_PUNCT_ENABLE: punct_enable_reg <= cfg_data[0];
                    default:          ;
                endcase
            end

            // take a byte: extend the word (x31 as shift and subtract) and queue events
            if (in_acc)
            begin
                pend_a_reg   <= ev_a;
                pend_p_reg   <= ev_p;
                pend_eof_reg <= end_mark;
                if (byte_present && !c_space && !c_punct)
                begin
                    cur_hash_reg  <= (cur_hash_reg << 5) - cur_hash_reg + {56'b0, text_byte};
                    cur_power_reg <= (cur_power_reg << 5) - cur_power_reg;
                    in_word_reg   <= 1'b1;
                end
            end

            // push the finished word or punctuation byte and set up the fold
            if (state_reg == S_PUSH)
            begin
                wr_ptr_reg     <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
                words_seen_reg <= words_seen_inc;
                rd_idx_reg     <= oldest_idx;
                fold_left_reg  <= nw_eff;
                fold_first_reg <= 1'b1;
                if (pend_a_reg)
                begin
                    pend_a_reg    <= 1'b0;
                    cur_hash_reg  <= '0;
                    cur_power_reg <= 64'd1;
                    in_word_reg   <= 1'b0;
                end
                else
                    pend_p_reg <= 1'b0;
            end

            if (state_reg == S_FRD)
            begin
                rd_idx_reg    <= (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
                fold_left_reg <= fold_left_reg - 1'b1;
            end

            if (state_reg == S_FUSE)
                fold_first_reg <= 1'b0;

            // signature or count goes into the holding slot
            if (commit)
            begin
                held_valid_reg <= 1'b1;
                if (state_reg == S_CHECK)
                begin
                    if (sig_count_reg != '1)
                        sig_count_reg <= sig_count_reg + 1'b1;
                end
                else
                begin
                    // end of file: clear per-file state
                    pend_eof_reg   <= 1'b0;
                    sig_count_reg  <= '0;
                    words_seen_reg <= '0;
                    in_word_reg    <= 1'b0;
                    cur_hash_reg   <= '0;
                    cur_power_reg  <= 64'd1;
                end
            end
            else if (state_reg == S_END && out_load)
                held_valid_reg <= 1'b0;

            // output register
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
            byte_reg <= text_byte;

        if (state_reg == S_FUSE && fold_first_reg)
            acc_h_reg <= rd_q.hash;
        else if (state_reg == S_FMUL && mul_rsp.done)
            acc_h_reg <= mul_rsp.value;

        if (commit)
        begin
            if (state_reg == S_CHECK)
            begin
                held_kind_reg    <= KIND_SIG;
                held_payload_reg <= acc_h_reg >> zero_bits_reg;
            end
            else
            begin
                held_kind_reg    <= KIND_COUNT;
                held_payload_reg <= HASH_W'(sig_count_reg);
            end
        end

        if (out_load)
        begin
            item_kind_reg <= held_kind_reg;
            payload_reg   <= held_payload_reg;
            run_last_reg  <= (state_reg == S_END);
        end
    end

    assign out_valid = out_valid_reg;
    assign item_kind = item_kind_reg;
    assign payload   = payload_reg;
    assign run_last  = run_last_reg;

endmodule

FILE: rtl/wngs_checker.sv
// Port-level checker for the signature generator, bound to the top level.
`include "word_ngram_signature_gen_macros.svh"

module wngs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            byte_present,
    input logic                            end_mark,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic                            item_kind,
    input logic [wngs_pkg::HASH_W-1:0]     payload,
    input logic                            run_last
);

    // a stalled result holds
    `WNGS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(payload) && $stable(item_kind) && $stable(run_last))

    // the count result always closes its input's run
    `WNGS_ASSERT_IMPLY(a_count_last, out_valid && item_kind, run_last)

    // end of file always produces a count, so the block is busy next
    `WNGS_ASSERT_NEXT(a_eof_busy, in_valid && !in_stall && end_mark, in_stall)

    // an empty request leaves the block ready
    `WNGS_ASSERT_NEXT(a_empty_ready, in_valid && !in_stall && !byte_present && !end_mark, !in_stall)

endmodule

bind word_ngram_signature_gen wngs_checker u_wngs_checker (.*);
